// File: rtl/sicl_pkg.sv
// ----------------------------------------------------------------------------
// sicl_pkg
// Shared widths, codes, the pipeline item types and the divider step
// functions for the segment intersection classifier.
// ----------------------------------------------------------------------------
package sicl_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int D_W   = COORD_WIDTH + 1;      // coordinate differences
    localparam int P_W   = 2 * D_W;              // single cross products
    localparam int W_W   = P_W + 1;              // den, t and s numerators
    localparam int MAG_W = P_W;                  // magnitude of den / t numerator
    localparam int NUM_W = 3 * D_W;              // |t_num * d|
    localparam int QBITS = 2 * COORD_WIDTH - 2;  // quotient bits before saturation
    localparam int SUM_W = QBITS + 2;

    typedef enum logic [2:0] {
        REL_PARALLEL = 3'd0,
        REL_INSIDE   = 3'd1,
        REL_FORWARD  = 3'd2,
        REL_BACKWARD = 3'd3,
        REL_MIXED    = 3'd4
    } sicl_rel_t;

    typedef struct packed {
        logic [MAG_W-1:0]       rem;
        logic [QBITS-1:0]       low;
        logic [QBITS-1:0]       quo;
        logic                   neg;
        logic                   big;
        logic [COORD_WIDTH-1:0] start;
    } sicl_lane_t;

    typedef struct packed {
        logic             vld;
        sicl_rel_t        rel;
        logic             pv;
        logic [MAG_W-1:0] den;
        sicl_lane_t       x;
        sicl_lane_t       y;
    } sicl_div_t;

    typedef struct packed {
        logic                   sat;
        logic [COORD_WIDTH-1:0] val;
    } sicl_coord_t;

    // One restoring long-division step: bring down the next numerator bit.
    function automatic sicl_lane_t lane_step(input sicl_lane_t l,
                                             input logic [MAG_W-1:0] den);
        logic [MAG_W:0] r2;
        logic [MAG_W:0] d2;
        sicl_lane_t     o;
        o  = l;
        r2 = {l.rem, l.low[QBITS-1]};
        d2 = {1'b0, den};
        o.low = {l.low[QBITS-2:0], 1'b0};
        if (r2 >= d2)
        begin
            r2    = r2 - d2;
            o.quo = {l.quo[QBITS-2:0], 1'b1};
        end
        else
        begin
            o.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        o.rem = r2[MAG_W-1:0];
        return o;
    endfunction

    // Apply the sign, add the start point and clamp to the coordinate range.
    function automatic sicl_coord_t lane_out(input sicl_lane_t l);
        logic signed [SUM_W-1:0] qs;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        sicl_coord_t             o;
        qs  = {2'b00, l.quo};
        if (l.neg)
        begin
            qs = -qs;
        end
        sum = {{(SUM_W-COORD_WIDTH){l.start[COORD_WIDTH-1]}}, l.start} + qs;
        hi  = {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
        lo  = {{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
        o.sat = 1'b1;
        if (l.big)
        begin
            o.val = l.neg ? lo[COORD_WIDTH-1:0] : hi[COORD_WIDTH-1:0];
        end
        else if (sum > hi)
        begin
            o.val = hi[COORD_WIDTH-1:0];
        end
        else if (sum < lo)
        begin
            o.val = lo[COORD_WIDTH-1:0];
        end
        else
        begin
            o.sat = 1'b0;
            o.val = sum[COORD_WIDTH-1:0];
        end
        return o;
    endfunction

endpackage

// File: rtl/segment_intersection_classify_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_classify_unit
// Classifies a pair of 2D segments and gives their saturated crossing point.
// ----------------------------------------------------------------------------
// The unit takes one segment pair per clock while in_stall is low and returns one
// result item per pair, in order, through six set-up stages, a chain of 62
// long-division cells (one quotient bit each for x and y) and an output
// register. The whole pipeline holds while a finished result is stalled.
// extend_lines resets to 1; cfg_ready is always high.
module segment_intersection_classify_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  a_start_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  a_start_y,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  a_end_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  a_end_y,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  b_start_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  b_start_y,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  b_end_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]  b_end_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        relation,
    output logic                              point_valid,
    output logic [sicl_pkg::COORD_WIDTH-1:0]  cross_x,
    output logic [sicl_pkg::COORD_WIDTH-1:0]  cross_y,
    output logic                              saturated
);

    localparam int QBITS = sicl_pkg::QBITS;

    logic                  ext_reg;
    logic                  en;
    sicl_pkg::sicl_div_t   chain [0:QBITS];
    sicl_pkg::sicl_coord_t cx, cy;

    logic                              out_valid_reg;
    logic [2:0]                        relation_reg;
    logic                              point_valid_reg;
    logic [sicl_pkg::COORD_WIDTH-1:0]  cross_x_reg, cross_y_reg;
    logic                              saturated_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ext_reg <= cfg_data;
        end
    end

    sicl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (in_valid),
        .extend_lines (ext_reg),
        .a_start_x    (a_start_x),
        .a_start_y    (a_start_y),
        .a_end_x      (a_end_x),
        .a_end_y      (a_end_y),
        .b_start_x    (b_start_x),
        .b_start_y    (b_start_y),
        .b_end_x      (b_end_x),
        .b_end_y      (b_end_y),
        .div_out      (chain[0])
    );

    for (genvar k = 0; k < QBITS; k++)
    begin : g_cell
        sicl_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[k]),
            .dout  (chain[k+1])
        );
    end

    always_comb
    begin
        cx = sicl_pkg::lane_out(chain[QBITS].x);
        cy = sicl_pkg::lane_out(chain[QBITS].y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            relation_reg    <= '0;
            point_valid_reg <= 1'b0;
            cross_x_reg     <= '0;
            cross_y_reg     <= '0;
            saturated_reg   <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg   <= chain[QBITS].vld;
            relation_reg    <= chain[QBITS].rel;
            point_valid_reg <= chain[QBITS].pv;
            cross_x_reg     <= chain[QBITS].pv ? cx.val : '0;
            cross_y_reg     <= chain[QBITS].pv ? cy.val : '0;
            saturated_reg   <= chain[QBITS].pv && (cx.sat || cy.sat);
        end
    end

    assign out_valid   = out_valid_reg;
    assign relation    = relation_reg;
    assign point_valid = point_valid_reg;
    assign cross_x     = cross_x_reg;
    assign cross_y     = cross_y_reg;
    assign saturated   = saturated_reg;

    // A point that is not reported carries no coordinates and no clamp flag.
    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_valid) |-> (cross_x == '0 && cross_y == '0 && !saturated))
        else $error("unreported crossing carries data");

    a_parallel_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && relation == sicl_pkg::REL_PARALLEL) |-> !point_valid)
        else $error("parallel pair reports a point");

    // Input is held exactly when a finished item waits on the output.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output back-pressure");

    a_range_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_valid && !ext_reg) |-> (relation == sicl_pkg::REL_INSIDE))
        else $error("point reported outside segments with extension off");

endmodule

// File: rtl/sicl_front.sv
// ----------------------------------------------------------------------------
// sicl_front
// Differences, cross products, classification and the crossing numerators,
// ending in the set-up of the long-division cell chain.
// ----------------------------------------------------------------------------
module sicl_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_vld,
    input  logic                               extend_lines,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   a_start_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   a_start_y,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   a_end_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   a_end_y,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   b_start_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   b_start_y,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   b_end_x,
    input  logic [sicl_pkg::COORD_WIDTH-1:0]   b_end_y,
    output sicl_pkg::sicl_div_t                div_out
);

    localparam int CW    = sicl_pkg::COORD_WIDTH;
    localparam int D_W   = sicl_pkg::D_W;
    localparam int P_W   = sicl_pkg::P_W;
    localparam int W_W   = sicl_pkg::W_W;
    localparam int MAG_W = sicl_pkg::MAG_W;
    localparam int NUM_W = sicl_pkg::NUM_W;
    localparam int QBITS = sicl_pkg::QBITS;

    // Stage 1: differences.
    logic                  s1_vld_reg;
    logic signed [D_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ox_reg, oy_reg;
    logic [CW-1:0]         s1_ax_reg, s1_ay_reg;
    // Stage 2: products.
    logic                  s2_vld_reg;
    logic signed [P_W-1:0] p_den0_reg, p_den1_reg, p_t0_reg, p_t1_reg, p_s0_reg, p_s1_reg;
    logic signed [D_W-1:0] s2_dax_reg, s2_day_reg;
    logic [CW-1:0]         s2_ax_reg, s2_ay_reg;
    // Stage 3: den and numerators.
    logic                  s3_vld_reg;
    logic signed [W_W-1:0] den_reg, tn_reg, sn_reg;
    logic signed [D_W-1:0] s3_dax_reg, s3_day_reg;
    logic [CW-1:0]         s3_ax_reg, s3_ay_reg;
    // Stage 4: sign-normalised and classified.
    logic                  s4_vld_reg;
    sicl_pkg::sicl_rel_t   s4_rel_reg;
    logic                  s4_pv_reg;
    logic [MAG_W-1:0]      s4_den_reg, s4_tmag_reg;
    logic [D_W-1:0]        s4_dxm_reg, s4_dym_reg;
    logic                  s4_nx_reg, s4_ny_reg;
    logic [CW-1:0]         s4_ax_reg, s4_ay_reg;
    // Stage 5: partial products of |t_num| * |d|.
    logic                  s5_vld_reg;
    sicl_pkg::sicl_rel_t   s5_rel_reg;
    logic                  s5_pv_reg;
    logic [MAG_W-1:0]      s5_den_reg;
    logic [P_W-1:0]        ppxl_reg, ppxh_reg, ppyl_reg, ppyh_reg;
    logic                  s5_nx_reg, s5_ny_reg;
    logic [CW-1:0]         s5_ax_reg, s5_ay_reg;
    // Stage 6: division set-up.
    sicl_pkg::sicl_div_t   div_reg;

    logic signed [W_W-1:0] den_n, tn_n, sn_n, tabs;
    logic                  den_zero, t_ge0, s_ge0, in_both;
    sicl_pkg::sicl_rel_t   rel;
    logic [NUM_W-1:0]      numx, numy;
    sicl_pkg::sicl_lane_t  lx, ly;

    always_comb
    begin
        den_zero = (den_reg == '0);
        den_n    = den_reg[W_W-1] ? -den_reg : den_reg;
        tn_n     = den_reg[W_W-1] ? -tn_reg  : tn_reg;
        sn_n     = den_reg[W_W-1] ? -sn_reg  : sn_reg;
        tabs     = tn_n[W_W-1] ? -tn_n : tn_n;
        t_ge0    = !tn_n[W_W-1];
        s_ge0    = !sn_n[W_W-1];
        in_both  = t_ge0 && s_ge0 && (tn_n <= den_n) && (sn_n <= den_n);
        priority if (den_zero)
            rel = sicl_pkg::REL_PARALLEL;
        else if (in_both)
            rel = sicl_pkg::REL_INSIDE;
        else if (t_ge0 && s_ge0)
            rel = sicl_pkg::REL_FORWARD;
        else if (!t_ge0 && !s_ge0)
            rel = sicl_pkg::REL_BACKWARD;
        else
            rel = sicl_pkg::REL_MIXED;
    end

    always_comb
    begin
        numx = {{D_W{1'b0}}, ppxl_reg} + {ppxh_reg[NUM_W-D_W-1:0], {D_W{1'b0}}};
        numy = {{D_W{1'b0}}, ppyl_reg} + {ppyh_reg[NUM_W-D_W-1:0], {D_W{1'b0}}};
        lx.rem   = {{(MAG_W-NUM_W+QBITS){1'b0}}, numx[NUM_W-1:QBITS]};
        lx.low   = numx[QBITS-1:0];
        lx.quo   = '0;
        lx.neg   = s5_nx_reg;
        lx.big   = (lx.rem >= s5_den_reg);
        lx.start = s5_ax_reg;
        ly.rem   = {{(MAG_W-NUM_W+QBITS){1'b0}}, numy[NUM_W-1:QBITS]};
        ly.low   = numy[QBITS-1:0];
        ly.quo   = '0;
        ly.neg   = s5_ny_reg;
        ly.big   = (ly.rem >= s5_den_reg);
        ly.start = s5_ay_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            div_reg    <= '0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            div_reg.vld <= s5_vld_reg;
            div_reg.rel <= s5_rel_reg;
            div_reg.pv  <= s5_pv_reg;
            div_reg.den <= s5_den_reg;
            div_reg.x   <= lx;
            div_reg.y   <= ly;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg   <= {a_end_x[CW-1], a_end_x} - {a_start_x[CW-1], a_start_x};
            day_reg   <= {a_end_y[CW-1], a_end_y} - {a_start_y[CW-1], a_start_y};
            dbx_reg   <= {b_end_x[CW-1], b_end_x} - {b_start_x[CW-1], b_start_x};
            dby_reg   <= {b_end_y[CW-1], b_end_y} - {b_start_y[CW-1], b_start_y};
            ox_reg    <= {a_start_x[CW-1], a_start_x} - {b_start_x[CW-1], b_start_x};
            oy_reg    <= {a_start_y[CW-1], a_start_y} - {b_start_y[CW-1], b_start_y};
            s1_ax_reg <= a_start_x;
            s1_ay_reg <= a_start_y;

            p_den0_reg <= dby_reg * dax_reg;
            p_den1_reg <= dbx_reg * day_reg;
            p_t0_reg   <= dbx_reg * oy_reg;
            p_t1_reg   <= dby_reg * ox_reg;
            p_s0_reg   <= dax_reg * oy_reg;
            p_s1_reg   <= day_reg * ox_reg;
            s2_dax_reg <= dax_reg;
            s2_day_reg <= day_reg;
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;

            den_reg    <= {p_den0_reg[P_W-1], p_den0_reg} - {p_den1_reg[P_W-1], p_den1_reg};
            tn_reg     <= {p_t0_reg[P_W-1], p_t0_reg} - {p_t1_reg[P_W-1], p_t1_reg};
            sn_reg     <= {p_s0_reg[P_W-1], p_s0_reg} - {p_s1_reg[P_W-1], p_s1_reg};
            s3_dax_reg <= s2_dax_reg;
            s3_day_reg <= s2_day_reg;
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;

            s4_rel_reg  <= rel;
            s4_pv_reg   <= !den_zero && (extend_lines || in_both);
            s4_den_reg  <= den_n[MAG_W-1:0];
            s4_tmag_reg <= tabs[MAG_W-1:0];
            s4_dxm_reg  <= s3_dax_reg[D_W-1] ? -s3_dax_reg : s3_dax_reg;
            s4_dym_reg  <= s3_day_reg[D_W-1] ? -s3_day_reg : s3_day_reg;
            s4_nx_reg   <= tn_n[W_W-1] ^ s3_dax_reg[D_W-1];
            s4_ny_reg   <= tn_n[W_W-1] ^ s3_day_reg[D_W-1];
            s4_ax_reg   <= s3_ax_reg;
            s4_ay_reg   <= s3_ay_reg;

            s5_rel_reg <= s4_rel_reg;
            s5_pv_reg  <= s4_pv_reg;
            s5_den_reg <= s4_den_reg;
            ppxl_reg   <= s4_tmag_reg[D_W-1:0] * s4_dxm_reg;
            ppxh_reg   <= s4_tmag_reg[MAG_W-1:D_W] * s4_dxm_reg;
            ppyl_reg   <= s4_tmag_reg[D_W-1:0] * s4_dym_reg;
            ppyh_reg   <= s4_tmag_reg[MAG_W-1:D_W] * s4_dym_reg;
            s5_nx_reg  <= s4_nx_reg;
            s5_ny_reg  <= s4_ny_reg;
            s5_ax_reg  <= s4_ax_reg;
            s5_ay_reg  <= s4_ay_reg;
        end
    end

    assign div_out = div_reg;

endmodule

// File: rtl/sicl_div_cell.sv
// ----------------------------------------------------------------------------
// sicl_div_cell
// One cell of the long-division chain: one quotient bit for each coordinate.
// ----------------------------------------------------------------------------
module sicl_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  sicl_pkg::sicl_div_t din,
    output sicl_pkg::sicl_div_t dout
);

    sicl_pkg::sicl_div_t cell_reg;
    sicl_pkg::sicl_div_t cell_next;

    always_comb
    begin
        cell_next   = din;
        cell_next.x = sicl_pkg::lane_step(din.x, din.den);
        cell_next.y = sicl_pkg::lane_step(din.y, din.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment intersection classifier testbench
// Streams segment pairs through the unit with random gaps and output stalls,
// predicts relation, crossing point and saturation with wide exact integer
// arithmetic, and checks every result item in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  CW        = sicl_pkg::COORD_WIDTH;
    localparam int  LATENCY   = 69;
    localparam longint LIMIT  = 1500000;

    typedef logic [CW-1:0] coord_t;
    typedef coord_t pair_t [8];

    typedef struct {
        sicl_pkg::sicl_rel_t rel;
        logic                pv;
        coord_t              cx;
        coord_t              cy;
        logic                sat;
    } crossing_t;

    // Exact crossing coordinate: start + trunc(tn*d/den), clamped; den > 0.
    function automatic coord_t crossing_coord(input logic signed [127:0] start,
                                              input logic signed [127:0] tn,
                                              input logic signed [127:0] d,
                                              input logic signed [127:0] den,
                                              inout logic sat);
        logic signed [127:0] num, mag, q, sum, hi, lo;
        logic                neg;
        hi  = (128'sd1 <<< (CW - 1)) - 1;
        lo  = -hi - 1;
        num = tn * d;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = mag / den;
        if (q >= (128'sd1 <<< 62))
        begin
            sat = 1'b1;
            return neg ? lo[CW-1:0] : hi[CW-1:0];
        end
        sum = start + (neg ? -q : q);
        if (sum > hi)
        begin
            sat = 1'b1;
            return hi[CW-1:0];
        end
        if (sum < lo)
        begin
            sat = 1'b1;
            return lo[CW-1:0];
        end
        return sum[CW-1:0];
    endfunction

    function automatic crossing_t classify_pair(input pair_t p, input logic ext);
        logic signed [127:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        logic signed [127:0] dax, day, dbx, dby, ox, oy, den, tn, sn;
        logic                in_both;
        crossing_t           r;
        ax1 = $signed(p[0]); ay1 = $signed(p[1]);
        ax2 = $signed(p[2]); ay2 = $signed(p[3]);
        bx1 = $signed(p[4]); by1 = $signed(p[5]);
        bx2 = $signed(p[6]); by2 = $signed(p[7]);
        dax = ax2 - ax1; day = ay2 - ay1;
        dbx = bx2 - bx1; dby = by2 - by1;
        ox  = ax1 - bx1; oy  = ay1 - by1;
        den = dby * dax - dbx * day;
        tn  = dbx * oy - dby * ox;
        sn  = dax * oy - day * ox;
        r.rel = sicl_pkg::REL_PARALLEL;
        r.pv  = 1'b0;
        r.cx  = '0;
        r.cy  = '0;
        r.sat = 1'b0;
        if (den != 0)
        begin
            if (den < 0)
            begin
                den = -den;
                tn  = -tn;
                sn  = -sn;
            end
            in_both = tn >= 0 && sn >= 0 && tn <= den && sn <= den;
            if (in_both)
                r.rel = sicl_pkg::REL_INSIDE;
            else if (tn >= 0 && sn >= 0)
                r.rel = sicl_pkg::REL_FORWARD;
            else if (tn < 0 && sn < 0)
                r.rel = sicl_pkg::REL_BACKWARD;
            else
                r.rel = sicl_pkg::REL_MIXED;
            r.pv = ext || in_both;
            if (r.pv)
            begin
                r.cx = crossing_coord(ax1, tn, dax, den, r.sat);
                r.cy = crossing_coord(ay1, tn, day, den, r.sat);
            end
        end
        return r;
    endfunction

    class crossing_board;
        crossing_t pending_q[$];
        logic      extend = 1'b1;
        int        errors = 0;

        task report(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_pair(input pair_t p);
            pending_q.insert(pending_q.size(), classify_pair(p, extend));
        endfunction

        task check_result(input crossing_t got);
            crossing_t e;
            if (pending_q.size() == 0)
            begin
                report("result item with nothing expected");
                return;
            end
            e = pending_q.pop_front();
            if (got.rel !== e.rel)
                report($sformatf("relation %0d, expected %0d", got.rel, e.rel));
            if (got.pv !== e.pv)
                report($sformatf("point_valid %0b, expected %0b", got.pv, e.pv));
            if (got.cx !== e.cx)
                report($sformatf("cross_x %h, expected %h", got.cx, e.cx));
            if (got.cy !== e.cy)
                report($sformatf("cross_y %h, expected %h", got.cy, e.cy));
            if (got.sat !== e.sat)
                report($sformatf("saturated %0b, expected %0b", got.sat, e.sat));
        endtask
    endclass

    logic   clk;
    logic   rst_n;
    logic   cfg_valid;
    logic   cfg_ready;
    logic   cfg_data;
    logic   in_valid;
    logic   in_stall;
    coord_t a_start_x, a_start_y, a_end_x, a_end_y;
    coord_t b_start_x, b_start_y, b_end_x, b_end_y;
    logic   out_valid;
    logic   out_stall;
    logic [2:0] relation;
    logic   point_valid;
    coord_t cross_x, cross_y;
    logic   saturated;

    crossing_board board;
    logic          long_hold;
    longint        cycles;

    segment_intersection_classify_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_start_x   (a_start_x),
        .a_start_y   (a_start_y),
        .a_end_x     (a_end_x),
        .a_end_y     (a_end_y),
        .b_start_x   (b_start_x),
        .b_start_y   (b_start_y),
        .b_end_x     (b_end_x),
        .b_end_y     (b_end_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .relation    (relation),
        .point_valid (point_valid),
        .cross_x     (cross_x),
        .cross_y     (cross_y),
        .saturated   (saturated)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: mostly short stalls, now and then a long one, and one
    // long hold-off on request so that the pipeline fills and stalls its input.
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            n = $urandom_range(0, 99);
            if (n < 55)
                out_stall <= 1'b0;
            else if (n < 95)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        crossing_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.rel = sicl_pkg::sicl_rel_t'(relation);
            got.pv  = point_valid;
            got.cx  = cross_x;
            got.cy  = cross_y;
            got.sat = saturated;
            board.check_result(got);
        end
    end

    task automatic send_pair(input pair_t p, input bit gaps);
        int g;
        in_valid  <= 1'b1;
        a_start_x <= p[0]; a_start_y <= p[1];
        a_end_x   <= p[2]; a_end_y   <= p[3];
        b_start_x <= p[4]; b_start_y <= p[5];
        b_end_x   <= p[6]; b_end_y   <= p[7];
        do
            @(posedge clk);
        while (in_stall);
        board.note_pair(p);
        g = 0;
        if (gaps)
        begin
            g = $urandom_range(0, 99);
            g = (g < 60) ? 0 : (g < 95) ? $urandom_range(1, 4) : $urandom_range(10, 50);
        end
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Waits until every result item is in, then lets the pipeline drain.
    task automatic drain;
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_extend(input logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.extend = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic coord_t random_coord(input int kind);
        int e;
        case (kind)
            0: return $urandom();
            1:
            begin
                e = $urandom_range(0, 3);
                return (e == 0) ? 32'h8000_0000 : (e == 1) ? 32'h7fff_ffff :
                       (e == 2) ? 32'h0 : 32'hffff_ffff;
            end
            default: return coord_t'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic pair_t random_pair;
        pair_t p;
        int    n, k;
        coord_t dx, dy;
        n = $urandom_range(0, 99);
        k = (n < 55) ? 2 : (n < 85) ? 0 : 1;
        foreach (p[i])
            p[i] = random_coord((k == 1 && $urandom_range(0, 1)) ? 2 : k);
        n = $urandom_range(0, 99);
        if (n < 10)
        begin
            // B is A shifted: parallel, sometimes collinear
            dx = random_coord(2);
            dy = ($urandom_range(0, 1)) ? random_coord(2) : '0;
            p[4] = p[0] + dx; p[5] = p[1] + dy;
            p[6] = p[2] + dx; p[7] = p[3] + dy;
        end
        else if (n < 15)
        begin
            p[4] = p[2];
            p[5] = p[3];
        end
        else if (n < 18)
        begin
            p[2] = p[0];
            p[3] = p[1];
        end
        return p;
    endfunction

    task automatic send_directed;
        pair_t d[$];
        coord_t mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        d.insert(d.size(), '{default: '0});
        d.insert(d.size(), '{'h100, 'h100, 'h100, 'h100, 0, 0, 'h200, 'h300});
        d.insert(d.size(), '{0, 0, 'h400, 'h400, 0, 'h400, 'h400, 0});
        d.insert(d.size(), '{0, 0, 'h100, 'h100, 'h400, 0, 'h400, -'h100});
        d.insert(d.size(), '{'h300, 'h300, 'h400, 'h400, 'h100, 0, 'h100, -'h100});
        d.insert(d.size(), '{0, 0, 'h100, 0, 'h300, 'h100, 'h300, 'h400});
        d.insert(d.size(), '{0, 0, 'h400, 'h400, 'h400, 'h400, 'h800, 0});
        d.insert(d.size(), '{0, 0, 'h400, 0, 'h100, 'h200, 'h300, 'h200});
        d.insert(d.size(), '{0, 0, 'h400, 0, 'h100, 'h100, 'h200, 'h300});
        d.insert(d.size(), '{mn, mn, mx, mx, mn, mx, mx, mn});
        d.insert(d.size(), '{mx, mx, mn, mn, mx, mn, mn, mx});
        d.insert(d.size(), '{mn, mn, mn + 1, mn, mx, mx, mx, mx - 1});
        d.insert(d.size(), '{mx, 0, mx - 1, 1, mn, 0, mn, 1});
        d.insert(d.size(), '{0, 0, 1, 1, 'h1000, 0, 'h1000, 1});
        d.insert(d.size(), '{mx, mx, mx - 1, mx, 0, mn, 1, mn});
        d.insert(d.size(), '{'hffff_ffff, 'hffff_ffff, 1, 1, mx, mn, mn, mx});
        d.insert(d.size(), '{0, 0, 3, 0, 1, 1, 2, -1});
        d.insert(d.size(), '{0, 0, 'h100, 'h100, 'h200, 'h200, 'h300, 'h300});
        foreach (d[i])
            send_pair(d[i], i[0]);
    endtask

    initial
    begin
        board     = new();
        cycles    = 0;
        long_hold = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        a_start_x = '0; a_start_y = '0; a_end_x = '0; a_end_y = '0;
        b_start_x = '0; b_start_y = '0; b_end_x = '0; b_end_y = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        write_extend(1'b0);
        send_directed();

        for (int phase = 0; phase < 3; phase++)
        begin
            write_extend(phase[0] ? 1'b0 : 1'b1);
            if (phase == 0)
                long_hold = 1'b1;
            for (int i = 0; i < 570; i++)
                send_pair(random_pair(), 1'b1);
        end

        drain();
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
